>>> rtl/so3_pkg.sv
package so3_pkg;

   localparam int NStages = 30;
   // Stages around the CORDIC: two setup, 32 root, 16 divide, 3 reduce, 3 product.
   localparam int PipeDepth = NStages + 56;
   localparam logic [33:0] PiQ30 = 34'd3373259426;
   localparam logic [33:0] TwoPiQ30 = 34'd6746518852;
   localparam logic [33:0] HalfPiQ30 = 34'd1686629713;
   localparam logic signed [33:0] GainInv = 34'sd652032874;
   localparam logic signed [15:0] OneQ14 = 16'sd16384;

   function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      begin
         case (i)
            5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;  5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;  5'd9: v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF; 5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF; 5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F; 5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004; 5'd29: v = 32'h00000002;
            default: v = 32'h0;
         endcase
         return $signed({2'b00, v});
      end
   endfunction

endpackage

>>> rtl/so3_pipe.sv
// Generic pipeline stage tracker: one valid bit per stage with a shared stall.
module so3_pipe (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   output logic [so3_pkg::PipeDepth-1:0] valid
);
   localparam int Depth = so3_pkg::PipeDepth;
   logic [Depth-1:0] valid_ff;
   logic [Depth-1:0] valid_in;

   assign valid_in = {valid_ff[Depth-2:0], in_valid};
   assign valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end
endmodule

>>> rtl/so3_exponential_map_top.sv
// SO(3) exponential map, Rodrigues formula, fully pipelined.
// Input channel req_: rot_x, rot_y, rot_z in signed Q3.12 radians. A word is
// taken when req_valid is high and req_stall is low.
// Output channel rsp_: the nine entries m00..m22 of the rotation matrix in
// signed Q1.14, saturated to plus or minus one. A zero vector gives identity.
// Throughput: one word per cycle unless rsp_stall holds the pipeline. From
// acceptance to rsp_valid a word passes two setup stages, a 32-stage square
// root, a 16-stage restoring divider for the axis, three angle-reduction
// stages, the 30-stage CORDIC and three product stages.
// The whole pipeline moves as one; when rsp_stall is high while the last stage
// holds a word, every stage holds, and req_stall is raised only then, so no
// word is lost or repeated.
// Reset clears all valid bits; data registers carry no reset.
module so3_exponential_map_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [15:0] req_rot_x,
   input  logic signed [15:0] req_rot_y,
   input  logic signed [15:0] req_rot_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22
);
   localparam int NC = so3_pkg::NStages;
   localparam int SqB = 32;            // root bits of floor(sqrt(s<<32))
   localparam int DvB = 15;            // quotient bits (values <= 2^15 before clamp)
   localparam int Depth = so3_pkg::PipeDepth;

   logic adv;
   logic [Depth-1:0] vld;
   assign adv = !(vld[Depth-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld[Depth-1];

   so3_pipe u_pipe (.clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_valid), .valid(vld));

   // ---------- stage 0: squares ----------
   logic signed [15:0] w_ff [0:2];
   logic [31:0] sq_ff [0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff[0] <= req_rot_x; w_ff[1] <= req_rot_y; w_ff[2] <= req_rot_z;
         sq_ff[0] <= 32'(req_rot_x * req_rot_x);
         sq_ff[1] <= 32'(req_rot_y * req_rot_y);
         sq_ff[2] <= 32'(req_rot_z * req_rot_z);
      end
   end

   // ---------- stage 1: sum s (Q.24, < 2^32) ----------
   logic [31:0] s_ff;
   logic signed [15:0] w1_ff [0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= 32'(34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]));
         w1_ff <= w_ff;
      end
   end

   // ---------- square root: one root bit per stage ----------
   // Radicand v = s<<32 (64 bits). Remainder kept 34 bits wide.
   logic [63:0] sv_ff [0:SqB];
   logic [33:0] sr_ff [0:SqB];
   logic [31:0] sq_root_ff [0:SqB];
   logic signed [15:0] sw_ff [0:SqB][0:2];
   always_comb begin
      sv_ff[0] = {s_ff, 32'd0};
      sr_ff[0] = '0;
      sq_root_ff[0] = '0;
      sw_ff[0] = w1_ff;
   end
   for (genvar g = 0; g < SqB; g++) begin : g_sqrt
      logic [34:0] rem_t, trial;
      always_comb begin
         rem_t = {sr_ff[g][32:0], sv_ff[g][63:62]};
         trial = rem_t - {1'b0, sq_root_ff[g], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sv_ff[g+1] <= {sv_ff[g][61:0], 2'b00};
            sw_ff[g+1] <= sw_ff[g];
            if (!trial[34]) begin
               sr_ff[g+1] <= trial[33:0];
               sq_root_ff[g+1] <= {sq_root_ff[g][30:0], 1'b1};
            end else begin
               sr_ff[g+1] <= rem_t[33:0];
               sq_root_ff[g+1] <= {sq_root_ff[g][30:0], 1'b0};
            end
         end
      end
   end

   // ---------- divider: three lanes, one quotient bit per stage ----------
   // q = (mag*2^30 + n/2) / n; q <= 2^15 since mag*2^16 <= n.
   logic [31:0] dn_ff [0:DvB+1];
   logic [46:0] dnum_ff [0:DvB+1][0:2];
   logic [32:0] drem_ff [0:DvB+1][0:2];
   logic [DvB:0] dq_ff [0:DvB+1][0:2];
   logic [2:0] dneg_ff [0:DvB+1];
   logic dzero_ff [0:DvB+1];
   always_comb begin
      dn_ff[0] = sq_root_ff[SqB];
      dzero_ff[0] = (sq_root_ff[SqB] == '0);
      for (int l = 0; l < 3; l++) begin
         dnum_ff[0][l] = {1'b0, 16'(sw_ff[SqB][l] < 0 ? -sw_ff[SqB][l] : sw_ff[SqB][l]),
                          30'd0} + 47'(sq_root_ff[SqB][31:1]);
         drem_ff[0][l] = '0;
         dq_ff[0][l] = '0;
         dneg_ff[0][l] = sw_ff[SqB][l][15];
      end
   end
   // Initial remainder = num >> 15 < 2n (since q < 2^16); then 15 more bits.
   for (genvar g = 0; g <= DvB; g++) begin : g_div
      logic [32:0] rt [0:2];
      logic [32:0] df [0:2];
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (g == 0) rt[l] = {1'b0, dnum_ff[g][l][46:15]};
            else rt[l] = {drem_ff[g][l][31:0], dnum_ff[g][l][46]};
            df[l] = rt[l] - {1'b0, dn_ff[g]};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dn_ff[g+1] <= dn_ff[g];
            dneg_ff[g+1] <= dneg_ff[g];
            dzero_ff[g+1] <= dzero_ff[g];
            for (int l = 0; l < 3; l++) begin
               if (g == 0) dnum_ff[g+1][l] <= {dnum_ff[g][l][14:0], 32'd0};
               else dnum_ff[g+1][l] <= {dnum_ff[g][l][45:0], 1'b0};
               if (!df[l][32]) begin
                  drem_ff[g+1][l] <= df[l];
                  dq_ff[g+1][l] <= {dq_ff[g][l][DvB-1:0], 1'b1};
               end else begin
                  drem_ff[g+1][l] <= rt[l];
                  dq_ff[g+1][l] <= {dq_ff[g][l][DvB-1:0], 1'b0};
               end
            end
         end
      end
   end
   // Division has DvB+1 = 16 stages; remaining fixed stages before CORDIC.
   // Stage A: axis clamp and angle reduction prep.
   logic signed [15:0] u_ff [0:2];
   logic [33:0] ang_ff;
   logic az_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 3; l++) begin
            logic [15:0] q;
            q = (dq_ff[DvB+1][l] > 16'd16384) ? 16'd16384 : dq_ff[DvB+1][l];
            u_ff[l] <= dneg_ff[DvB+1][l] ? -$signed(q) : $signed(q);
         end
         ang_ff <= {dn_ff[DvB+1], 2'b00};
         az_ff <= dzero_ff[DvB+1];
      end
   end
   // Stage B: modulo 2pi (angle < 3*2pi at most, two compares).
   logic signed [15:0] ub_ff [0:2];
   logic [33:0] rb_ff;
   logic bz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic [34:0] t;
         t = (ang_ff >= so3_pkg::TwoPiQ30) ? 35'(ang_ff) - 35'(so3_pkg::TwoPiQ30)
                                           : 35'(ang_ff);
         if (t >= 35'(so3_pkg::TwoPiQ30)) t = t - 35'(so3_pkg::TwoPiQ30);
         rb_ff <= t[33:0];
         ub_ff <= u_ff;
         bz_ff <= az_ff;
      end
   end
   // Stage C: fold into [-pi/2, pi/2].
   logic signed [35:0] cr_ff [0:NC];
   logic signed [33:0] cx_ff [0:NC];
   logic signed [33:0] cy_ff [0:NC];
   logic cflip_ff [0:NC];
   logic cz_ff [0:NC];
   logic signed [15:0] cu_ff [0:NC][0:2];
   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [35:0] r;
         logic flip;
         r = $signed({2'b00, rb_ff});
         flip = 1'b0;
         if (r >= $signed({2'b00, so3_pkg::PiQ30})) r = r - $signed({2'b00, so3_pkg::TwoPiQ30});
         if (r > $signed({2'b00, so3_pkg::HalfPiQ30})) begin
            r = $signed({2'b00, so3_pkg::PiQ30}) - r; flip = 1'b1;
         end else if (r < -$signed({2'b00, so3_pkg::HalfPiQ30})) begin
            r = -$signed({2'b00, so3_pkg::PiQ30}) - r; flip = 1'b1;
         end
         cflip_ff[0] <= flip;
         cr_ff[0] <= r;
         cx_ff[0] <= so3_pkg::GainInv;
         cy_ff[0] <= '0;
         cz_ff[0] <= bz_ff;
         cu_ff[0] <= ub_ff;
      end
   end
   for (genvar g = 0; g < NC; g++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv) begin
            cflip_ff[g+1] <= cflip_ff[g];
            cz_ff[g+1] <= cz_ff[g];
            cu_ff[g+1] <= cu_ff[g];
            if (!cr_ff[g][35]) begin
               cx_ff[g+1] <= cx_ff[g] - (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] + (cx_ff[g] >>> g);
               cr_ff[g+1] <= cr_ff[g] - 36'(so3_pkg::atan_q30(5'(g)));
            end else begin
               cx_ff[g+1] <= cx_ff[g] + (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] - (cx_ff[g] >>> g);
               cr_ff[g+1] <= cr_ff[g] + 36'(so3_pkg::atan_q30(5'(g)));
            end
         end
      end
   end

   // ---------- products ----------
   // P1: sin, c1 = 2^30 - cos, K and KK entries.
   logic signed [33:0] sn_ff, c1_ff;
   logic signed [15:0] k_ff [0:8];
   logic signed [29:0] kk_ff [0:8];
   logic pz1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [15:0] ux, uy, uz;
         logic signed [33:0] cs;
         ux = cu_ff[NC][0]; uy = cu_ff[NC][1]; uz = cu_ff[NC][2];
         cs = cflip_ff[NC] ? -cx_ff[NC] : cx_ff[NC];
         sn_ff <= cy_ff[NC];
         c1_ff <= 34'sd1073741824 - cs;
         k_ff[0] <= '0; k_ff[1] <= -uz; k_ff[2] <= uy;
         k_ff[3] <= uz; k_ff[4] <= '0; k_ff[5] <= -ux;
         k_ff[6] <= -uy; k_ff[7] <= ux; k_ff[8] <= '0;
         kk_ff[0] <= 30'(-(uz*uz) - (uy*uy));
         kk_ff[1] <= 30'(uy*ux);
         kk_ff[2] <= 30'(uz*ux);
         kk_ff[3] <= 30'(ux*uy);
         kk_ff[4] <= 30'(-(uz*uz) - (ux*ux));
         kk_ff[5] <= 30'(uz*uy);
         kk_ff[6] <= 30'(ux*uz);
         kk_ff[7] <= 30'(uy*uz);
         kk_ff[8] <= 30'(-(uy*uy) - (ux*ux));
         pz1_ff <= cz_ff[NC];
      end
   end
   // P2: sin*K and (c1*KK)>>14.
   logic signed [48:0] ps_ff [0:8];
   logic signed [49:0] pc_ff [0:8];
   logic pz2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 9; e++) begin
            ps_ff[e] <= 49'(sn_ff * k_ff[e]);
            pc_ff[e] <= 50'((64'(c1_ff) * 64'(kk_ff[e])) >>> 14);
         end
         pz2_ff <= pz1_ff;
      end
   end
   // P3: sum, round, clamp.
   logic signed [15:0] m_ff [0:8];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < 9; e++) begin
            logic signed [51:0] acc;
            logic signed [21:0] r;
            acc = 52'(ps_ff[e]) + 52'(pc_ff[e]) + 52'sd536870912;
            if (e == 0 || e == 4 || e == 8) acc = acc + (52'sd1 <<< 44);
            r = 22'(acc >>> 30);
            if (pz2_ff) m_ff[e] <= (e == 0 || e == 4 || e == 8) ? so3_pkg::OneQ14 : '0;
            else if (r > 22'sd16384) m_ff[e] <= so3_pkg::OneQ14;
            else if (r < -22'sd16384) m_ff[e] <= -so3_pkg::OneQ14;
            else m_ff[e] <= 16'(r);
         end
      end
   end

   assign rsp_m00 = m_ff[0]; assign rsp_m01 = m_ff[1]; assign rsp_m02 = m_ff[2];
   assign rsp_m10 = m_ff[3]; assign rsp_m11 = m_ff[4]; assign rsp_m12 = m_ff[5];
   assign rsp_m20 = m_ff[6]; assign rsp_m21 = m_ff[7]; assign rsp_m22 = m_ff[8];
endmodule

>>> sim/so3_exponential_map_checker.sv
`timescale 1ns / 1ps

module so3_exponential_map_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic signed [15:0] req_rot_x,
   input  logic signed [15:0] req_rot_y,
   input  logic signed [15:0] req_rot_z,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic signed [15:0] rsp_m00,
   input  logic signed [15:0] rsp_m01,
   input  logic signed [15:0] rsp_m02,
   input  logic signed [15:0] rsp_m10,
   input  logic signed [15:0] rsp_m11,
   input  logic signed [15:0] rsp_m12,
   input  logic signed [15:0] rsp_m20,
   input  logic signed [15:0] rsp_m21,
   input  logic signed [15:0] rsp_m22,
   output int   mismatches,
   output int   matrices_pending
);

   typedef logic [8:0][15:0] matrix_type;

   localparam longint PiQ30 = 64'sd3373259426;
   localparam longint TwoPiQ30 = 64'sd6746518852;
   localparam longint HalfPiQ30 = 64'sd1686629713;
   localparam longint CordicStart = 64'sd652032874;
   localparam longint UnitQ14 = 64'sd16384;

   localparam longint ArctanQ30 [30] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
   };

   localparam string EntryName [9] = '{
      "m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"
   };

   // Expected matrices in arrival order; the block holds far fewer than 256 words.
   matrix_type expected_ring [256];
   logic [7:0] wr_index = '0;
   logic [7:0] rd_index = '0;
   int outstanding = 0;
   int error_count = 0;

   function automatic matrix_type rodrigues_matrix(input logic signed [15:0] rx,
                                                   input logic signed [15:0] ry,
                                                   input logic signed [15:0] rz);
      longint w [3];
      longint axis [3];
      longint skew [3][3];
      longint skew_sq [3][3];
      longint unsigned sum_sq, root, rem, probe, mag, quo;
      longint angle, x, y, dx, dy, sn, cs, one_minus_cos, acc;
      bit flip;
      matrix_type m;
      w[0] = rx;
      w[1] = ry;
      w[2] = rz;
      sum_sq = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
      if (sum_sq == 0) begin
         for (int i = 0; i < 9; i++)
            m[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
         return m;
      end
      // Bitwise integer square root of the squared norm in Q.56 gives the angle in Q.28.
      rem = sum_sq << 32;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
         mag = (w[i] < 0) ? -w[i] : w[i];
         quo = ((mag << 30) + (root >> 1)) / root;
         if (quo > UnitQ14) quo = UnitQ14;
         axis[i] = (w[i] < 0) ? -longint'(quo) : longint'(quo);
      end
      skew[0][0] = 0;        skew[0][1] = -axis[2]; skew[0][2] = axis[1];
      skew[1][0] = axis[2];  skew[1][1] = 0;        skew[1][2] = -axis[0];
      skew[2][0] = -axis[1]; skew[2][1] = axis[0];  skew[2][2] = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            skew_sq[i][j] = 0;
            for (int k = 0; k < 3; k++) skew_sq[i][j] += skew[i][k] * skew[k][j];
         end
      // Reduce the Q.30 angle into [-pi/2, pi/2], remembering a cosine sign flip.
      angle = longint'(root << 2) % TwoPiQ30;
      flip = 1'b0;
      if (angle >= PiQ30) angle -= TwoPiQ30;
      if (angle > HalfPiQ30) begin
         angle = PiQ30 - angle;
         flip = 1'b1;
      end else if (angle < -HalfPiQ30) begin
         angle = -PiQ30 - angle;
         flip = 1'b1;
      end
      x = CordicStart;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (angle >= 0) begin
            x -= dx;
            y += dy;
            angle -= ArctanQ30[i];
         end else begin
            x += dx;
            y -= dy;
            angle += ArctanQ30[i];
         end
      end
      sn = y;
      cs = flip ? -x : x;
      one_minus_cos = (longint'(1) << 30) - cs;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = (i == j) ? (longint'(1) << 44) : 0;
            acc += sn * skew[i][j];
            acc += (one_minus_cos * skew_sq[i][j]) >>> 14;
            acc = (acc + (longint'(1) << 29)) >>> 30;
            if (acc > UnitQ14) acc = UnitQ14;
            if (acc < -UnitQ14) acc = -UnitQ14;
            m[i * 3 + j] = acc[15:0];
         end
      return m;
   endfunction

   matrix_type observed;

   assign observed = {rsp_m22, rsp_m21, rsp_m20, rsp_m12, rsp_m11, rsp_m10,
                      rsp_m02, rsp_m01, rsp_m00};
   assign matrices_pending = outstanding;
   assign mismatches = error_count;

   always @(posedge clock) begin
      matrix_type wanted;
      int taken;
      int given;
      taken = 0;
      given = 0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_ring[wr_index] = rodrigues_matrix(req_rot_x, req_rot_y, req_rot_z);
            wr_index = wr_index + 8'd1;
            taken = 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (outstanding + taken == 0) begin
               $error("matrix word arrived with no rotation vector outstanding");
               error_count++;
            end else begin
               wanted = expected_ring[rd_index];
               rd_index = rd_index + 8'd1;
               given = 1;
               for (int i = 0; i < 9; i++)
                  if (observed[i] !== wanted[i]) begin
                     $error("%s: expected %0d, got %0d", EntryName[i],
                            $signed(wanted[i]), $signed(observed[i]));
                     error_count++;
                  end
            end
         end
         outstanding <= outstanding + taken - given;
      end
   end

endmodule

>>> sim/so3_exponential_map_top_tb.sv
`timescale 1ns / 1ps

module so3_exponential_map_top_tb;

   localparam int RandomVectors = 1500;
   localparam int IdleLimit = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_rot_x = '0;
   logic signed [15:0] req_rot_y = '0;
   logic signed [15:0] req_rot_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [15:0] rsp_m20, rsp_m21, rsp_m22;
   int mismatches;
   int matrices_pending;
   int idle_cycles = 0;
   int stall_left = 0;
   bit steady = 1'b0;

   always #5 clock = ~clock;

   so3_exponential_map_top dut (.*);

   so3_exponential_map_checker checker_inst (.*);

   // After each matrix word it takes, the receiver stalls for a random number of cycles, none in steady phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_valid && !rsp_stall)
            stall_left <= steady ? 0 : $urandom_range(0, 18);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rot_x <= x;
      req_rot_y <= y;
      req_rot_z <= z;
      // The stall is stable by the falling edge, so it tells whether the next rise takes the word.
      forever begin
         @(negedge clock);
         if (!req_stall) break;
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] draw_component(input int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 128)) - 64);
         2: return 16'($signed($urandom_range(0, 6)) - 3);
         default: return 16'($signed($urandom_range(0, 800)) - 400 +
                             ($urandom_range(0, 1) ? 12868 : -12868));
      endcase
   endfunction

   initial begin
      int style;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_vector(0, 0, 0);
      send_vector(1, 0, 0);
      send_vector(0, -1, 0);
      send_vector(0, 0, 1);
      send_vector(32767, 32767, 32767);
      send_vector(-32768, -32768, -32768);
      send_vector(-32768, 0, 0);
      send_vector(32767, 0, 0);
      send_vector(32767, -32768, 32767);
      send_vector(12868, 0, 0);
      send_vector(0, 12868, 0);
      send_vector(0, 0, -12868);
      send_vector(6434, 0, 0);
      send_vector(0, -6434, 0);
      send_vector(25736, 0, 0);
      send_vector(7429, 7429, 7429);
      send_vector(-1, 1, -1);
      send_vector(16'sh5555, 16'shAAAA, 16'sh5555);
      send_vector(16'shAAAA, 16'sh5555, 16'shAAAA);
      send_vector(12867, 12869, 0);

      // Let the pipeline drain completely before the random part.
      req_valid <= 1'b0;
      @(posedge clock);
      while (matrices_pending != 0) @(posedge clock);

      for (int i = 0; i < RandomVectors; i++) begin
         if (i % 150 == 0) steady = ($urandom_range(0, 3) == 0);
         style = $urandom_range(0, 9);
         if (style < 5)
            send_vector(draw_component(0), draw_component(0), draw_component(0));
         else if (style < 7)
            send_vector(draw_component(1), draw_component(1), draw_component(1));
         else if (style < 8)
            send_vector(draw_component(2), draw_component(2), draw_component(2));
         else
            send_vector(draw_component(3), draw_component(1), draw_component(2));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (matrices_pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
